>>> sv/pid_controller_antiwindup_assert.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion forms for the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// same-cycle implication
`define PID_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pid assertion failed");

// next-cycle implication
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pid assertion failed");

`endif

>>> sv/pid_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Sequencer state codes, operation codes and register indexes.
// ----------------------------------------------------------------------------
package pid_pkg;

   typedef logic [3:0] state_type;

   localparam state_type S_IDLE     = 4'd0;
   localparam state_type S_MUL_P    = 4'd1;
   localparam state_type S_P_FIN    = 4'd2;
   localparam state_type S_MUL_I1   = 4'd3;
   localparam state_type S_I1_FIN   = 4'd4;
   localparam state_type S_MUL_I2   = 4'd5;
   localparam state_type S_I2_FIN   = 4'd6;
   localparam state_type S_D_START  = 4'd7;
   localparam state_type S_MUL_D    = 4'd8;
   localparam state_type S_D_FIN    = 4'd9;
   localparam state_type S_DIV_D    = 4'd10;
   localparam state_type S_DV_FIN   = 4'd11;
   localparam state_type S_DD_START = 4'd12;
   localparam state_type S_MUL_DD   = 4'd13;
   localparam state_type S_DD_FIN   = 4'd14;
   localparam state_type S_DONE     = 4'd15;

   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_KP   = 3'd0;
   localparam reg_index_type REG_KI   = 3'd1;
   localparam reg_index_type REG_KD   = 3'd2;
   localparam reg_index_type REG_KDD  = 3'd3;
   localparam reg_index_type REG_WL   = 3'd4;
   localparam reg_index_type REG_DT   = 3'd5;
   localparam reg_index_type REG_DSRC = 3'd6;

   localparam logic OP_RUN  = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [31:0] DT_RESET = 32'd42949673;

endpackage

>>> sv/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Positional fixed-point PID step with bit-serial multiply and divide.
// ----------------------------------------------------------------------------
// A run transaction steps through one shared shift-add multiplier that
// retires one multiplier bit per cycle (up to five products) and a
// restoring divider that retires one quotient bit per cycle (only when the
// D term differentiates the error). A disabled or held integral skips the
// two integral multiplies; the measured-rate D source skips the divide. A
// load transaction writes the integral register and gives no result. The
// input stalls while a step is in progress; a finished result waits in
// the output register, and the next transaction is taken as soon as the
// sequencer is back at idle.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [2:0]                   csr_index,
   input  logic [31:0]                  csr_wr_data,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_error,
   input  logic signed [DATA_WIDTH-1:0] req_pv_rate,
   input  logic signed [DATA_WIDTH-1:0] req_pv_accel,
   input  logic signed [DATA_WIDTH-1:0] req_integral_value,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_command,
   output logic                         rsp_saturated
);

`include "pid_controller_antiwindup_assert.svh"

   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int MCW  = W + 32;            // multiplicand width
   localparam int PW   = MCW + 32;          // product width
   localparam int DVW  = W + 65 - F;        // dividend / quotient width
   localparam int CNTW = $clog2(DVW);
   localparam int CMPW = (W > 31) ? W : 31;

   localparam logic [CNTW-1:0] MUL_LAST = CNTW'(31);
   localparam logic [CNTW-1:0] DIV_LAST = CNTW'(DVW - 1);

   // ---- config registers
   logic [31:0] kp_ff, ki_ff, kd_ff, kdd_ff, dt_ff;
   logic [30:0] wl_ff;
   logic        dsrc_ff;

   // ---- datapath and control
   pid_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic [MCW-1:0]     mcand_ff, mcand_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [DVW-1:0]     dq_ff, dq_in;
   logic [31:0]        rem_ff, rem_in;
   logic signed [W-1:0] err_ff, err_in;
   logic signed [W-1:0] rate_ff, rate_in;
   logic signed [W-1:0] accel_ff, accel_in;
   logic signed [W-1:0] p_ff, p_in;
   logic signed [W-1:0] d_ff, d_in;
   logic signed [W-1:0] dd_ff, dd_in;
   logic signed [W-1:0] integral_ff, integral_in;
   logic signed [W-1:0] last_err_ff, last_err_in;
   logic               clip_ff, clip_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] rsp_command_ff, rsp_command_in;
   logic               rsp_saturated_ff, rsp_saturated_in;

   // ---- helpers
   function automatic logic [W:0] fin(input logic neg, input logic [PW-1:0] v);
      logic [PW-1:0] cap;
      logic [W-1:0]  m;
      logic          c;
      cap = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
      c   = v > cap;
      m   = c ? cap[W-1:0] : v[W-1:0];
      fin = {c, neg ? (~m + W'(1)) : m};
   endfunction

   function automatic logic [W:0] sat(input logic signed [W+1:0] v);
      logic signed [W+1:0] hi;
      logic signed [W+1:0] lo;
      hi = $signed({3'b000, {(W-1){1'b1}}});
      lo = $signed({3'b111, {(W-1){1'b0}}});
      if (v > hi) begin
         sat = {1'b1, hi[W-1:0]};
      end else if (v < lo) begin
         sat = {1'b1, lo[W-1:0]};
      end else begin
         sat = {1'b0, v[W-1:0]};
      end
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      mag = v[W-1] ? (~v + W'(1)) : v;
   endfunction

   // ---- combinational step logic
   logic                run_ok;
   logic [CMPW-1:0]     int_mag, wl_ext;
   logic [MCW:0]        mul_sum;
   logic [32:0]         div_t, div_d;
   logic                div_ge;
   logic signed [W:0]   diff;
   logic [W:0]          diff_mag;
   logic [W:0]          fin_r;
   logic [W:0]          sat_r;
   logic signed [W+1:0] int_sum, cmd_sum;
   logic                rsp_free;
   logic                req_take;

   assign req_stall = (state_ff != pid_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign int_mag = CMPW'(mag(integral_ff));
   assign wl_ext  = CMPW'(wl_ff);
   // anti-windup: at the limit, only a correcting error may accumulate
   assign run_ok  = (wl_ff == '0) || (int_mag < wl_ext) ||
                    (integral_ff > 0 && err_ff < 0) || (integral_ff < 0 && err_ff > 0);

   // shift-add multiply: one multiplier bit per cycle
   assign mul_sum = {1'b0, prod_ff[PW-1:32]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   // restoring divide: one quotient bit per cycle
   assign div_t   = {rem_ff, dq_ff[DVW-1]};
   assign div_d   = div_t - {1'b0, dt_ff};
   assign div_ge  = div_t >= {1'b0, dt_ff};

   assign diff     = $signed({err_ff[W-1], err_ff}) - $signed({last_err_ff[W-1], last_err_ff});
   assign diff_mag = diff[W] ? (~diff + (W+1)'(1)) : diff;

   assign int_sum = $signed({{2{integral_ff[W-1]}}, integral_ff}) +
                    $signed({{2{fin_r[W-1]}}, fin_r[W-1:0]});
   assign cmd_sum = $signed({{2{p_ff[W-1]}}, p_ff}) +
                    $signed({{2{integral_ff[W-1]}}, integral_ff}) +
                    $signed({{2{d_ff[W-1]}}, d_ff}) +
                    $signed({{2{dd_ff[W-1]}}, dd_ff});

   always_comb begin
      fin_r = '0;
      sat_r = '0;
      unique case (state_ff)
         pid_pkg::S_P_FIN:  fin_r = fin(err_ff[W-1], prod_ff >> F);
         pid_pkg::S_I2_FIN: fin_r = fin(err_ff[W-1], prod_ff >> (F + 32));
         pid_pkg::S_D_FIN:  fin_r = fin(rate_ff[W-1], prod_ff >> F);
         pid_pkg::S_DV_FIN: fin_r = fin(diff[W], {{(PW-DVW){1'b0}}, dq_ff});
         pid_pkg::S_DD_FIN: fin_r = fin(accel_ff > 0, prod_ff >> F);
         default:           fin_r = '0;
      endcase
      if (state_ff == pid_pkg::S_I2_FIN) begin
         sat_r = sat(int_sum);
      end else begin
         sat_r = sat(cmd_sum);
      end
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff + CNTW'(1);
      mcand_in         = mcand_ff;
      prod_in          = {mul_sum, prod_ff[31:1]};
      dq_in            = dq_ff;
      rem_in           = rem_ff;
      err_in           = err_ff;
      rate_in          = rate_ff;
      accel_in         = accel_ff;
      p_in             = p_ff;
      d_in             = d_ff;
      dd_in            = dd_ff;
      integral_in      = integral_ff;
      last_err_in      = last_err_ff;
      clip_in          = clip_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_command_in   = rsp_command_ff;
      rsp_saturated_in = rsp_saturated_ff;

      unique case (state_ff)
         pid_pkg::S_IDLE: begin
            cnt_in  = '0;
            prod_in = prod_ff;
            if (req_take) begin
               if (req_operation == pid_pkg::OP_LOAD) begin
                  integral_in = req_integral_value;
               end else begin
                  err_in   = req_error;
                  rate_in  = req_pv_rate;
                  accel_in = req_pv_accel;
                  clip_in  = 1'b0;
                  mcand_in = MCW'(mag(req_error));
                  prod_in  = {{MCW{1'b0}}, kp_ff};
                  state_in = pid_pkg::S_MUL_P;
               end
            end
         end
         pid_pkg::S_MUL_P: begin
            if (cnt_ff == MUL_LAST) state_in = pid_pkg::S_P_FIN;
         end
         pid_pkg::S_P_FIN: begin
            p_in    = fin_r[W-1:0];
            clip_in = clip_ff | fin_r[W];
            cnt_in  = '0;
            if (ki_ff != '0 && run_ok) begin
               mcand_in = MCW'(mag(err_ff));
               prod_in  = {{MCW{1'b0}}, ki_ff};
               state_in = pid_pkg::S_MUL_I1;
            end else begin
               prod_in  = prod_ff;
               state_in = pid_pkg::S_D_START;
            end
         end
         pid_pkg::S_MUL_I1: begin
            if (cnt_ff == MUL_LAST) state_in = pid_pkg::S_I1_FIN;
         end
         pid_pkg::S_I1_FIN: begin
            // |err|*ki becomes the multiplicand for the dt pass
            mcand_in = prod_ff[MCW-1:0];
            prod_in  = {{MCW{1'b0}}, dt_ff};
            cnt_in   = '0;
            state_in = pid_pkg::S_MUL_I2;
         end
         pid_pkg::S_MUL_I2: begin
            if (cnt_ff == MUL_LAST) state_in = pid_pkg::S_I2_FIN;
         end
         pid_pkg::S_I2_FIN: begin
            integral_in = sat_r[W-1:0];
            clip_in     = clip_ff | fin_r[W] | sat_r[W];
            prod_in     = prod_ff;
            state_in    = pid_pkg::S_D_START;
         end
         pid_pkg::S_D_START: begin
            mcand_in = dsrc_ff ? MCW'(mag(rate_ff)) : MCW'(diff_mag);
            prod_in  = {{MCW{1'b0}}, kd_ff};
            cnt_in   = '0;
            state_in = pid_pkg::S_MUL_D;
         end
         pid_pkg::S_MUL_D: begin
            if (cnt_ff == MUL_LAST) state_in = pid_pkg::S_D_FIN;
         end
         pid_pkg::S_D_FIN: begin
            prod_in = prod_ff;
            cnt_in  = '0;
            if (dsrc_ff) begin
               d_in     = fin_r[W-1:0];
               clip_in  = clip_ff | fin_r[W];
               state_in = pid_pkg::S_DD_START;
            end else begin
               // scale to Q33.48 (at the default widths) ahead of the divide by dt
               dq_in    = {prod_ff[W+32:0], {(32-F){1'b0}}};
               rem_in   = '0;
               state_in = pid_pkg::S_DIV_D;
            end
         end
         pid_pkg::S_DIV_D: begin
            prod_in = prod_ff;
            rem_in  = div_ge ? div_d[31:0] : div_t[31:0];
            dq_in   = {dq_ff[DVW-2:0], div_ge};
            if (cnt_ff == DIV_LAST) state_in = pid_pkg::S_DV_FIN;
         end
         pid_pkg::S_DV_FIN: begin
            prod_in  = prod_ff;
            d_in     = fin_r[W-1:0];
            clip_in  = clip_ff | fin_r[W];
            state_in = pid_pkg::S_DD_START;
         end
         pid_pkg::S_DD_START: begin
            mcand_in = MCW'(mag(accel_ff));
            prod_in  = {{MCW{1'b0}}, kdd_ff};
            cnt_in   = '0;
            state_in = pid_pkg::S_MUL_DD;
         end
         pid_pkg::S_MUL_DD: begin
            if (cnt_ff == MUL_LAST) state_in = pid_pkg::S_DD_FIN;
         end
         pid_pkg::S_DD_FIN: begin
            prod_in  = prod_ff;
            dd_in    = fin_r[W-1:0];
            clip_in  = clip_ff | fin_r[W];
            state_in = pid_pkg::S_DONE;
         end
         pid_pkg::S_DONE: begin
            prod_in = prod_ff;
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_command_in   = sat_r[W-1:0];
               rsp_saturated_in = clip_ff | sat_r[W];
               last_err_in      = err_ff;
               state_in         = pid_pkg::S_IDLE;
            end
         end
         default: state_in = pid_pkg::S_IDLE;
      endcase
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pid_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         last_err_ff  <= '0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         kdd_ff       <= '0;
         wl_ff        <= '0;
         dt_ff        <= pid_pkg::DT_RESET;
         dsrc_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         last_err_ff  <= last_err_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               pid_pkg::REG_KP:   kp_ff  <= csr_wr_data;
               pid_pkg::REG_KI:   ki_ff  <= csr_wr_data;
               pid_pkg::REG_KD:   kd_ff  <= csr_wr_data;
               pid_pkg::REG_KDD:  kdd_ff <= csr_wr_data;
               pid_pkg::REG_WL:   wl_ff  <= csr_wr_data[30:0];
               pid_pkg::REG_DT:   if (csr_wr_data != '0) dt_ff <= csr_wr_data;
               pid_pkg::REG_DSRC: dsrc_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff           <= cnt_in;
      mcand_ff         <= mcand_in;
      prod_ff          <= prod_in;
      dq_ff            <= dq_in;
      rem_ff           <= rem_in;
      err_ff           <= err_in;
      rate_ff          <= rate_in;
      accel_ff         <= accel_in;
      p_ff             <= p_in;
      d_ff             <= d_in;
      dd_ff            <= dd_in;
      clip_ff          <= clip_in;
      rsp_command_ff   <= rsp_command_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_command   = rsp_command_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // ---- assertions
   `PID_ASSERT_NEXT(a_run_starts, clock, reset,
      req_take && req_operation == pid_pkg::OP_RUN, state_ff == pid_pkg::S_MUL_P)
   `PID_ASSERT_NEXT(a_load_writes, clock, reset,
      req_take && req_operation == pid_pkg::OP_LOAD,
      integral_ff == $past(req_integral_value) && state_ff == pid_pkg::S_IDLE)
   `PID_ASSERT_NOW(a_div_count, clock, reset,
      state_ff == pid_pkg::S_DIV_D, cnt_ff <= DIV_LAST)
   `PID_ASSERT_NEXT(a_done_emits, clock, reset,
      state_ff == pid_pkg::S_DONE && rsp_free, rsp_valid_ff && state_ff == pid_pkg::S_IDLE)

endmodule
